// File: sv/iou_box_tracker_smoother_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box tracker
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef IOU_BOX_TRACKER_SMOOTHER_DEFINES_SVH
`define IOU_BOX_TRACKER_SMOOTHER_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define IBTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked at every clock edge outside reset.
`define IBTS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

// File: sv/iou_bts_pkg.sv
// ----------------------------------------------------------------------------
// Box tracker package
// Sequencer states, register indexes and reset values, and fixed field widths.
// ----------------------------------------------------------------------------
package iou_bts_pkg;

    // Fixed field widths.
    localparam int AREA_W    = 25;
    localparam int THR_W     = 16;
    localparam int ALPHA_W   = 9;
    localparam int SLOT_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 25;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_AREA_FLOOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IOU_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 2'd2;

    // Register reset values.
    localparam logic [AREA_W-1:0]  AREA_FLOOR_RST = 25'd400;
    localparam logic [THR_W-1:0]   IOU_THR_RST    = 16'd19661;
    localparam logic [ALPHA_W-1:0] ALPHA_RST      = 9'd179;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE      = 9'd256;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AREA,
        ST_SCAN,
        ST_RD,
        ST_PAREA,
        ST_UNI,
        ST_RHS,
        ST_CMP,
        ST_BREAD,
        ST_BLEND,
        ST_STORE,
        ST_OUT
    } t_state;

endpackage

// File: sv/iou_bts_if.sv
// ----------------------------------------------------------------------------
// Box tracker channels
// Detection input channel and tracked box result channel.
// ----------------------------------------------------------------------------
interface iou_bts_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] box_x;
    logic [COORD_BITS-1:0] box_y;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;
    logic [24:0]           twice_area;
    logic                  last_in_frame;

    modport source (output valid, box_x, box_y, box_width, box_height, twice_area,
                    last_in_frame, input ready);
    modport sink (input valid, box_x, box_y, box_width, box_height, twice_area,
                  last_in_frame, output ready);
endinterface

interface iou_bts_out_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  kept;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [COORD_BITS-1:0] out_width;
    logic [COORD_BITS-1:0] out_height;
    logic                  matched;
    logic [5:0]            matched_slot;
    logic                  table_full;
    logic                  frame_done;

    modport source (output valid, kept, out_x, out_y, out_width, out_height, matched,
                    matched_slot, table_full, frame_done, input ready);
    modport sink (input valid, kept, out_x, out_y, out_width, out_height, matched,
                  matched_slot, table_full, frame_done, output ready);
endinterface

// File: sv/iou_box_tracker_smoother.sv
// ----------------------------------------------------------------------------
// Greedy IoU box tracker with exponential smoothing
// Matches each kept detection to the previous frame and blends the pair.
// ----------------------------------------------------------------------------
// Usage: detections arrive one per transfer on i_box; each produces exactly
// one result transfer on o_res, in order. The block takes one detection at a
// time: i_box.ready is high only while nothing is in work.
// Timing: a dropped box offers its result on the cycle after its transfer.
// A kept box first takes its area, then for each previous slot reads the
// memory and, unless the slot is taken, forms the overlap; if the boxes
// overlap it goes on to the partner area, the union and two cross products,
// all through one shared multiplier. The scan then ends, a matched box is
// blended and the box is stored before its result is offered.
// After the result transfer the block returns to idle before the next
// detection is taken.
// The tables and their taken marks live in one memory of two banks that swap
// on the end-of-frame transfer, so no copy is needed; a taken mark is cleared
// as its entry is stored. Configuration writes on i_cfg_* take effect at once;
// the user must make them only while idle, as the block does not enforce it.
// Reset: registers take their defaults and both counts go to zero; memory
// contents are not cleared and need no clearing pass.
// Stall: a result holds on o_res until o_res.ready; no new detection is
// taken meanwhile.
// ----------------------------------------------------------------------------
`include "iou_box_tracker_smoother_defines.svh"

module iou_box_tracker_smoother #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [iou_bts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [iou_bts_pkg::CFG_W-1:0]     i_cfg_data,
    iou_bts_in_if.sink                        i_box,
    iou_bts_out_if.source                     o_res
);
    import iou_bts_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int IW  = $clog2(MAX_BOXES);
    localparam int CW  = $clog2(MAX_BOXES + 1);
    localparam int EW  = 4 * CB;
    localparam int NW  = (2 * CB > THR_W) ? 2 * CB : THR_W;
    localparam int DW  = (2 * CB + 1 > THR_W + 1) ? 2 * CB + 1 : THR_W + 1;
    localparam int MW  = DW;
    localparam int PW  = 2 * MW;
    localparam int MD  = 2 ** (IW + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_BOXES);
    localparam logic [DW-1:0] DEN_ONE  = DW'(65536);

    // Configuration registers.
    logic [AREA_W-1:0]  r_area_floor;
    logic [THR_W-1:0]   r_iou_thr;
    logic [ALPHA_W-1:0] r_alpha;

    // Table memory: bank r_bank holds the previous frame.
    logic [EW-1:0] mem [MD];
    logic          r_tmark [MD];
    logic [EW-1:0] r_rd;
    logic          r_tk_rd;
    logic          r_bank;
    logic [CW-1:0] r_prev_cnt, n_prev_cnt;
    logic [CW-1:0] r_next_cnt, n_next_cnt;

    // Sequencer and working registers.
    t_state        r_state, n_state;
    logic [EW-1:0] r_cur, n_cur;
    logic [EW-1:0] r_res, n_res;
    logic          r_last, n_last;
    logic          r_kept, n_kept;
    logic          r_found, n_found;
    logic          r_full, n_full;
    logic [CW-1:0] r_j, n_j;
    logic [IW-1:0] r_best, n_best;
    logic [2:0]    r_k, n_k;
    logic [2*CB-1:0] r_cur_area, n_cur_area;
    logic [2*CB-1:0] r_inter, n_inter;
    logic [2*CB-1:0] r_parea, n_parea;
    logic [DW-1:0] r_uni, n_uni;
    logic [NW-1:0] r_bnum, n_bnum;
    logic [DW-1:0] r_bden, n_bden;
    logic [PW-1:0] r_lhs, n_lhs;
    logic [PW-1:0] r_rhs, n_rhs;
    logic [PW-1:0] r_acc, n_acc;

    // Memory control and shared multiplier.
    logic            rd_en;
    logic [IW:0]     rd_addr;
    logic            wr_en;
    logic [MW-1:0]   op_a, op_b;
    logic [PW-1:0]   prod;
    logic [PW-1:0]   blend_sum;
    logic [CB-1:0]   iw, ih;
    logic [ALPHA_W-1:0] alpha_sat;
    logic            set_taken;
    logic            swap;

    function automatic logic [CB-1:0] coord(input logic [EW-1:0] e, input int k);
        coord = e[(3-k)*CB +: CB];
    endfunction

    // Overlap of two intervals given by start and length.
    function automatic logic [CB-1:0] overlap(input logic [CB-1:0] a0,
                                              input logic [CB-1:0] al,
                                              input logic [CB-1:0] b0,
                                              input logic [CB-1:0] bl);
        logic [CB:0] lo;
        logic [CB:0] ea;
        logic [CB:0] eb;
        logic [CB:0] hi;
        lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
        ea = {1'b0, a0} + {1'b0, al};
        eb = {1'b0, b0} + {1'b0, bl};
        hi = (ea < eb) ? ea : eb;
        overlap = (hi > lo) ? CB'(hi - lo) : '0;
    endfunction

    assign alpha_sat = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign iw = overlap(coord(r_cur, 0), coord(r_cur, 2), coord(r_rd, 0), coord(r_rd, 2));
    assign ih = overlap(coord(r_cur, 1), coord(r_cur, 3), coord(r_rd, 1), coord(r_rd, 3));
    assign prod = PW'(op_a) * PW'(op_b);
    assign blend_sum = r_acc + prod;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_floor <= AREA_FLOOR_RST;
            r_iou_thr    <= IOU_THR_RST;
            r_alpha      <= ALPHA_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AREA_FLOOR: r_area_floor <= i_cfg_data[AREA_W-1:0];
                REG_IOU_THR:    r_iou_thr    <= i_cfg_data[THR_W-1:0];
                REG_ALPHA:      r_alpha      <= i_cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // Table memory and taken marks with registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[{~r_bank, r_next_cnt[IW-1:0]}]     <= r_res;
            r_tmark[{~r_bank, r_next_cnt[IW-1:0]}] <= 1'b0;
        end else if (set_taken) begin
            r_tmark[{r_bank, r_best}] <= 1'b1;
        end
        if (rd_en) begin
            r_rd    <= mem[rd_addr];
            r_tk_rd <= r_tmark[rd_addr];
        end
    end

    // State register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_bank     <= 1'b0;
            r_prev_cnt <= '0;
            r_next_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_prev_cnt <= n_prev_cnt;
            r_next_cnt <= n_next_cnt;
            if (swap) begin
                r_bank <= ~r_bank;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_res      <= n_res;
        r_last     <= n_last;
        r_kept     <= n_kept;
        r_found    <= n_found;
        r_full     <= n_full;
        r_j        <= n_j;
        r_best     <= n_best;
        r_k        <= n_k;
        r_cur_area <= n_cur_area;
        r_inter    <= n_inter;
        r_parea    <= n_parea;
        r_uni      <= n_uni;
        r_bnum     <= n_bnum;
        r_bden     <= n_bden;
        r_lhs      <= n_lhs;
        r_rhs      <= n_rhs;
        r_acc      <= n_acc;
    end

    // Sequencer: next state, multiplier operands and memory control.
    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_res      = r_res;
        n_last     = r_last;
        n_kept     = r_kept;
        n_found    = r_found;
        n_full     = r_full;
        n_j        = r_j;
        n_best     = r_best;
        n_k        = r_k;
        n_cur_area = r_cur_area;
        n_inter    = r_inter;
        n_parea    = r_parea;
        n_uni      = r_uni;
        n_bnum     = r_bnum;
        n_bden     = r_bden;
        n_lhs      = r_lhs;
        n_rhs      = r_rhs;
        n_acc      = r_acc;
        n_prev_cnt = r_prev_cnt;
        n_next_cnt = r_next_cnt;
        op_a       = '0;
        op_b       = '0;
        rd_en      = 1'b0;
        rd_addr    = {r_bank, r_j[IW-1:0]};
        wr_en      = 1'b0;
        set_taken  = 1'b0;
        swap       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_box.valid) begin
                    n_cur   = {i_box.box_x, i_box.box_y, i_box.box_width, i_box.box_height};
                    n_last  = i_box.last_in_frame;
                    n_kept  = (i_box.twice_area > r_area_floor);
                    n_found = 1'b0;
                    n_full  = 1'b0;
                    n_best  = '0;
                    n_j     = '0;
                    n_bnum  = NW'(r_iou_thr);
                    n_bden  = DEN_ONE;
                    if (i_box.twice_area > r_area_floor) begin
                        n_res   = {i_box.box_x, i_box.box_y, i_box.box_width,
                                   i_box.box_height};
                        n_state = ST_AREA;
                    end else begin
                        n_res   = '0;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_AREA: begin
                op_a       = MW'(coord(r_cur, 2));
                op_b       = MW'(coord(r_cur, 3));
                n_cur_area = prod[2*CB-1:0];
                n_state    = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_j >= r_prev_cnt) begin
                    n_state = r_found ? ST_BREAD : ST_STORE;
                end else begin
                    rd_en   = 1'b1;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                // A slot already taken in this frame is skipped.
                if (r_tk_rd) begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_SCAN;
                end else begin
                    op_a    = MW'(iw);
                    op_b    = MW'(ih);
                    n_inter = prod[2*CB-1:0];
                    n_state = ST_PAREA;
                end
            end
            ST_PAREA: begin
                // No overlap never matches.
                if (r_inter == '0) begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_SCAN;
                end else begin
                    op_a    = MW'(coord(r_rd, 2));
                    op_b    = MW'(coord(r_rd, 3));
                    n_parea = prod[2*CB-1:0];
                    n_state = ST_UNI;
                end
            end
            ST_UNI: begin
                n_uni   = DW'(r_cur_area) + DW'(r_parea) - DW'(r_inter);
                op_a    = MW'(r_inter);
                op_b    = MW'(r_bden);
                n_lhs   = prod;
                n_state = ST_RHS;
            end
            ST_RHS: begin
                op_a    = MW'(r_bnum);
                op_b    = MW'(r_uni);
                n_rhs   = prod;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                // Strictly greater keeps the lowest slot on a tie.
                if (r_lhs > r_rhs) begin
                    n_bnum  = NW'(r_inter);
                    n_bden  = r_uni;
                    n_best  = r_j[IW-1:0];
                    n_found = 1'b1;
                end
                n_j     = r_j + 1'b1;
                n_state = ST_SCAN;
            end
            ST_BREAD: begin
                rd_en     = 1'b1;
                rd_addr   = {r_bank, r_best};
                set_taken = 1'b1;
                n_k       = '0;
                n_state   = ST_BLEND;
            end
            ST_BLEND: begin
                // Even steps weight the previous box, odd steps add the current one.
                if (!r_k[0]) begin
                    op_a  = MW'(alpha_sat);
                    op_b  = MW'(coord(r_rd, int'(r_k[2:1])));
                    n_acc = prod;
                end else begin
                    op_a = MW'(ALPHA_ONE - alpha_sat);
                    op_b = MW'(coord(r_cur, int'(r_k[2:1])));
                    n_res[(3 - int'(r_k[2:1]))*CB +: CB] = blend_sum[8 +: CB];
                end
                n_k = r_k + 1'b1;
                if (r_k == 3'd7) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                if (r_next_cnt < FULL_CNT) begin
                    wr_en      = 1'b1;
                    n_next_cnt = r_next_cnt + 1'b1;
                end else begin
                    n_full = 1'b1;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (o_res.ready) begin
                    if (r_last) begin
                        swap       = 1'b1;
                        n_prev_cnt = r_next_cnt;
                        n_next_cnt = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Channel outputs.
    assign i_box.ready        = (r_state == ST_IDLE);
    assign o_res.valid        = (r_state == ST_OUT);
    assign o_res.kept         = r_kept;
    assign o_res.out_x        = coord(r_res, 0);
    assign o_res.out_y        = coord(r_res, 1);
    assign o_res.out_width    = coord(r_res, 2);
    assign o_res.out_height   = coord(r_res, 3);
    assign o_res.matched      = r_found;
    assign o_res.matched_slot = r_found ? SLOT_W'(r_best) : '0;
    assign o_res.table_full   = r_full;
    assign o_res.frame_done   = r_last;

    // Checks.
    `IBTS_ASSERT_ALWAYS(a_cnt_bound, (r_next_cnt <= FULL_CNT) && (r_prev_cnt <= FULL_CNT), "count over depth")
    `IBTS_ASSERT_IMP(a_match_kept, o_res.valid && (o_res.matched || o_res.table_full), o_res.kept, "dropped box flagged")
    `IBTS_ASSERT_IMP(a_full_cnt, o_res.valid && o_res.table_full, r_next_cnt == FULL_CNT, "full with room left")
    `IBTS_ASSERT_IMP(a_swap_clear, o_res.valid && o_res.ready && o_res.frame_done, ##1 (r_next_cnt == '0), "count kept")

endmodule
